// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4,
        MODE_HEX3 = 3'd5,
        MODE_HEX4 = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_BYTE    = 3'd0,
        ST_DONE    = 3'd1,
        ST_NOQUOTE = 3'd2,
        ST_BADESC  = 3'd3,
        ST_BADHEX  = 3'd4,
        ST_ENDESC  = 3'd5,
        ST_ENDUNI  = 3'd6,
        ST_UNTERM  = 3'd7
    } t_status;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U         = 8'h75;

    localparam logic [15:0] UTF8_MAX1 = 16'h007F;
    localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [5:0]  UTF8_MASK  = 6'h3F;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_result;

    // Results produced by one accepted item, slot 0 goes out first.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_group;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.value = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Returns {known, byte} for the single-character escapes.
    function automatic logic [8:0] escape_decode(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/jsu_in_if.sv -----
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/jsu_out_if.sv -----
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- rtl/json_string_unescape_decoder_unit.sv -----
// Decodes a quoted JSON string one byte per transfer on i_in and delivers decoded
// bytes, a done marker or an error code on o_out, with last set on the final result
// of each input byte. The first result of a byte appears in the cycle after its
// transfer. While o_out is ready, a byte is taken every cycle if each byte yields
// at most one result, and the three-slot output register drains one result per
// cycle; a \u escape that encodes to two or three UTF-8 bytes holds i_in until its
// last result leaves. Errors return the decoder to waiting for an opening quote.
module json_string_unescape_decoder_unit
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic    accept;
    logic    in_ready;
    t_group  group;
    t_result result;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_end    (i_in.end_of_input),
        .o_group  (group)
    );

    jsu_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_group     (group),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .o_result    (result)
    );

    assign o_out.out_byte = result.out_byte;
    assign o_out.status   = result.status;
    assign o_out.last     = result.last;

endmodule

// ----- rtl/jsu_decode.sv -----
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_group     o_group
);

    t_mode       r_mode, n_mode;
    logic [11:0] r_acc, n_acc;

    t_hex        hex;
    logic [8:0]  esc;
    logic [15:0] cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_acc  <= 12'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

    always_comb begin
        hex = hex_decode(i_byte);
        esc = escape_decode(i_byte);
        cp  = {r_acc, hex.value};

        n_mode  = r_mode;
        n_acc   = r_acc;
        o_group = '0;

        case (r_mode)
            MODE_BODY: begin
                if (i_end) begin
                    n_mode = MODE_WAIT;
                    n_acc  = 12'd0;
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: 8'd0, status: ST_UNTERM, last: 1'b1};
                end else if (i_byte == CHAR_QUOTE) begin
                    n_mode = MODE_WAIT;
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: 8'd0, status: ST_DONE, last: 1'b1};
                end else if (i_byte == CHAR_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: i_byte, status: ST_BYTE, last: 1'b1};
                end
            end
            MODE_ESC: begin
                if (i_end) begin
                    n_mode = MODE_WAIT;
                    n_acc  = 12'd0;
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: 8'd0, status: ST_ENDESC, last: 1'b1};
                end else if (esc[8]) begin
                    n_mode = MODE_BODY;
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: esc[7:0], status: ST_BYTE, last: 1'b1};
                end else if (i_byte == CHAR_U) begin
                    n_mode = MODE_HEX1;
                    n_acc  = 12'd0;
                end else begin
                    n_mode = MODE_WAIT;
                    n_acc  = 12'd0;
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: 8'd0, status: ST_BADESC, last: 1'b1};
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                if (i_end || !hex.valid) begin
                    n_mode = MODE_WAIT;
                    n_acc  = 12'd0;
                    o_group.count  = 2'd1;
                    o_group.res[0] = '{out_byte: 8'd0,
                                       status: i_end ? ST_ENDUNI : ST_BADHEX,
                                       last: 1'b1};
                end else if (r_mode != MODE_HEX4) begin
                    n_acc  = {r_acc[7:0], hex.value};
                    n_mode = t_mode'(r_mode + 3'd1);
                end else begin
                    n_mode = MODE_BODY;
                    n_acc  = 12'd0;
                    if (cp <= UTF8_MAX1) begin
                        o_group.count  = 2'd1;
                        o_group.res[0] = '{out_byte: cp[7:0], status: ST_BYTE, last: 1'b1};
                    end else if (cp <= UTF8_MAX2) begin
                        o_group.count  = 2'd2;
                        o_group.res[0] = '{out_byte: UTF8_LEAD2 | {3'd0, cp[10:6]},
                                           status: ST_BYTE, last: 1'b0};
                        o_group.res[1] = '{out_byte: UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK},
                                           status: ST_BYTE, last: 1'b1};
                    end else begin
                        o_group.count  = 2'd3;
                        o_group.res[0] = '{out_byte: UTF8_LEAD3 | {4'd0, cp[15:12]},
                                           status: ST_BYTE, last: 1'b0};
                        o_group.res[1] = '{out_byte: UTF8_CONT | {2'd0, cp[11:6] & UTF8_MASK},
                                           status: ST_BYTE, last: 1'b0};
                        o_group.res[2] = '{out_byte: UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK},
                                           status: ST_BYTE, last: 1'b1};
                    end
                end
            end
            default: begin
                // Waiting for the opening quote; the unused code behaves the same.
                n_mode = MODE_WAIT;
                if (!i_end) begin
                    if (i_byte == CHAR_QUOTE) begin
                        n_mode = MODE_BODY;
                    end else begin
                        n_acc = 12'd0;
                        o_group.count  = 2'd1;
                        o_group.res[0] = '{out_byte: 8'd0, status: ST_NOQUOTE, last: 1'b1};
                    end
                end
            end
        endcase
    end

endmodule

// ----- rtl/jsu_outbuf.sv -----
module jsu_outbuf
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_group  i_group,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_result o_result
);

    t_result [2:0] r_slot, n_slot;
    logic [1:0]    r_cnt, n_cnt;
    logic          pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_result    = r_slot[0];
    assign pop         = o_out_valid && i_out_ready;
    // A new item may enter when no result is pending or when the last pending result leaves in this cycle.
    assign o_in_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (i_load && i_group.count != 2'd0) begin
            n_slot = i_group.res;
            n_cnt  = i_group.count;
        end else if (pop) begin
            n_slot = {r_slot[2], r_slot[2], r_slot[1]};
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

// ----- rtl/jsu_checker.sv -----
module jsu_checker
    import jsu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [2:0] i_out_status,
    input logic       i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_status) && $stable(i_out_last))
        else $error("output changed while stalled");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_BYTE |-> i_out_last && i_out_byte == 8'd0)
        else $error("non-byte result must be single, last and zero");

    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("multi-byte sequence broken");

    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

endmodule

bind json_string_unescape_decoder_unit jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);

// ----- test/json_string_unescape_decoder_unit_tb.sv -----
module json_string_unescape_decoder_unit_tb;
    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       eoi;
        logic       typed;
        logic [1:0] n_want;
        t_result    want;
    } t_row;

    localparam logic [7:0] ESC_LETTERS [8] =
        '{CHAR_QUOTE, CHAR_BACKSLASH, "/", "b", "f", "n", "r", "t"};
    localparam logic [15:0] BOUNDARY_POINTS [6] =
        '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};

    // Directed opening: typed rows carry their expected results, the rest use the predictor.
    t_row script [29] = '{
        '{"A",            1'b0, 1'b1, 2'd1, '{8'h00, ST_NOQUOTE, 1'b1}},
        '{8'h00,          1'b1, 1'b1, 2'd0, '0},
        '{CHAR_QUOTE,     1'b0, 1'b1, 2'd0, '0},
        '{8'h00,          1'b0, 1'b1, 2'd1, '{8'h00, ST_BYTE, 1'b1}},
        '{8'hFF,          1'b0, 1'b1, 2'd1, '{8'hFF, ST_BYTE, 1'b1}},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{"q",            1'b0, 1'b1, 2'd1, '{8'h00, ST_BADESC, 1'b1}},
        '{CHAR_QUOTE,     1'b0, 1'b0, 2'd0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CHAR_U,         1'b0, 1'b0, 2'd0, '0},
        '{"0",            1'b0, 1'b0, 2'd0, '0},
        '{"0",            1'b0, 1'b0, 2'd0, '0},
        '{"0",            1'b0, 1'b0, 2'd0, '0},
        '{"0",            1'b0, 1'b1, 2'd1, '{8'h00, ST_BYTE, 1'b1}},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CHAR_U,         1'b0, 1'b0, 2'd0, '0},
        '{"G",            1'b0, 1'b1, 2'd1, '{8'h00, ST_BADHEX, 1'b1}},
        '{CHAR_QUOTE,     1'b0, 1'b0, 2'd0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CHAR_U,         1'b0, 1'b0, 2'd0, '0},
        '{"F",            1'b0, 1'b0, 2'd0, '0},
        '{8'hFF,          1'b1, 1'b1, 2'd1, '{8'h00, ST_ENDUNI, 1'b1}},
        '{CHAR_QUOTE,     1'b0, 1'b0, 2'd0, '0},
        '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{8'h00,          1'b1, 1'b1, 2'd1, '{8'h00, ST_ENDESC, 1'b1}},
        '{CHAR_QUOTE,     1'b0, 1'b0, 2'd0, '0},
        '{8'h00,          1'b1, 1'b1, 2'd1, '{8'h00, ST_UNTERM, 1'b1}},
        '{CHAR_QUOTE,     1'b0, 1'b0, 2'd0, '0},
        '{CHAR_QUOTE,     1'b0, 1'b1, 2'd1, '{8'h00, ST_DONE, 1'b1}}
    };

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch();
    jsu_out_if out_ch();

    json_string_unescape_decoder_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_mode       model_mode = MODE_WAIT;
    logic [11:0] model_acc  = '0;
    t_result     pending_results [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int strings_done = 0;
    int mismatches   = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #800_000;
        $display("Timeout with %0d results still outstanding.", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_result make_result(input logic [7:0] v, input t_status st);
        t_result x;
        x.out_byte = v;
        x.status   = st;
        x.last     = 1'b0;
        return x;
    endfunction

    // Appends one result to the tail of the expectation queue.
    function automatic void queue_result(input t_result x);
        pending_results = {pending_results, x};
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        if (v < 4'd10) return 8'("0") + 8'(v);
        base = ($urandom_range(1) == 0) ? 8'("a") : 8'("A");
        return base + 8'(v) - 8'd10;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        foreach (ESC_LETTERS[k]) begin
            if (ESC_LETTERS[k] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(3))
            0:       return BOUNDARY_POINTS[$urandom_range(5)];
            1:       return 16'($urandom_range(16'h007F));
            2:       return 16'($urandom_range(16'h07FF, 16'h0080));
            default: return 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
    endfunction

    // Advances the decoder state by one accepted byte and returns the results it causes.
    task automatic unescape_step(input logic [7:0] b, input logic e,
                                 output int n, output t_result r [3]);
        int          d;
        logic [15:0] cp;
        logic        has_err;
        t_status     err_code;
        n        = 0;
        has_err  = 1'b0;
        err_code = ST_BYTE;
        foreach (r[k]) r[k] = '0;
        d = hex_nibble(b);
        case (model_mode)
            MODE_BODY: begin
                if (e) begin
                    has_err = 1'b1; err_code = ST_UNTERM;
                end else if (b == CHAR_QUOTE) begin
                    model_mode = MODE_WAIT;
                    r[0] = make_result(8'h00, ST_DONE); n = 1;
                end else if (b == CHAR_BACKSLASH) begin
                    model_mode = MODE_ESC;
                end else begin
                    r[0] = make_result(b, ST_BYTE); n = 1;
                end
            end
            MODE_ESC: begin
                if (e) begin
                    has_err = 1'b1; err_code = ST_ENDESC;
                end else if (b == CHAR_U) begin
                    model_mode = MODE_HEX1;
                    model_acc  = '0;
                end else begin
                    n = 1;
                    case (b)
                        CHAR_QUOTE:     r[0] = make_result(8'h22, ST_BYTE);
                        CHAR_BACKSLASH: r[0] = make_result(8'h5C, ST_BYTE);
                        "/":            r[0] = make_result(8'h2F, ST_BYTE);
                        "b":            r[0] = make_result(8'h08, ST_BYTE);
                        "f":            r[0] = make_result(8'h0C, ST_BYTE);
                        "n":            r[0] = make_result(8'h0A, ST_BYTE);
                        "r":            r[0] = make_result(8'h0D, ST_BYTE);
                        "t":            r[0] = make_result(8'h09, ST_BYTE);
                        default: begin
                            n = 0; has_err = 1'b1; err_code = ST_BADESC;
                        end
                    endcase
                    if (n == 1) model_mode = MODE_BODY;
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                if (e) begin
                    has_err = 1'b1; err_code = ST_ENDUNI;
                end else if (d < 0) begin
                    has_err = 1'b1; err_code = ST_BADHEX;
                end else if (model_mode != MODE_HEX4) begin
                    model_acc  = {model_acc[7:0], 4'(d)};
                    model_mode = t_mode'(model_mode + 3'd1);
                end else begin
                    cp = {model_acc, 4'(d)};
                    if (cp <= UTF8_MAX1) begin
                        r[0] = make_result(cp[7:0], ST_BYTE); n = 1;
                    end else if (cp <= UTF8_MAX2) begin
                        r[0] = make_result(UTF8_LEAD2 | 8'(cp >> 6), ST_BYTE);
                        r[1] = make_result(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK}, ST_BYTE);
                        n = 2;
                    end else begin
                        r[0] = make_result(UTF8_LEAD3 | 8'(cp >> 12), ST_BYTE);
                        r[1] = make_result(UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK}, ST_BYTE);
                        r[2] = make_result(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK}, ST_BYTE);
                        n = 3;
                    end
                    model_mode = MODE_BODY;
                    model_acc  = '0;
                end
            end
            default: begin
                model_mode = MODE_WAIT;
                if (!e) begin
                    if (b == CHAR_QUOTE) model_mode = MODE_BODY;
                    else begin
                        has_err = 1'b1; err_code = ST_NOQUOTE;
                    end
                end
            end
        endcase
        if (has_err) begin
            model_mode = MODE_WAIT;
            model_acc  = '0;
            r[0] = make_result(8'h00, err_code);
            n = 1;
        end
        if (n > 0) r[n-1].last = 1'b1;
    endtask

    task automatic transfer_item(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= e;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic feed(input logic [7:0] b, input logic e);
        int      n;
        t_result r [3];
        transfer_item(b, e);
        unescape_step(b, e, n, r);
        for (int k = 0; k < n; k++) queue_result(r[k]);
    endtask

    // Mostly well-formed random strings, some noise, broken escapes and early end of input.
    task automatic send_random_string();
        int          pick;
        logic [7:0]  b;
        logic [15:0] cp;
        if ($urandom_range(9) == 0) begin
            feed(8'($urandom_range(255)), $urandom_range(2) == 0);
            return;
        end
        feed(CHAR_QUOTE, 1'b0);
        repeat ($urandom_range(8)) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                do b = 8'($urandom_range(255)); while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
                feed(b, 1'b0);
            end else if (pick < 65) begin
                feed(CHAR_BACKSLASH, 1'b0);
                feed(ESC_LETTERS[$urandom_range(7)], 1'b0);
            end else if (pick < 88) begin
                cp = pick_code_point();
                feed(CHAR_BACKSLASH, 1'b0);
                feed(CHAR_U, 1'b0);
                for (int k = 3; k >= 0; k--) feed(hex_char(cp[4*k +: 4]), 1'b0);
            end else if (pick < 92) begin
                feed(CHAR_BACKSLASH, 1'b0);
                do b = 8'($urandom_range(255)); while (is_escape_letter(b) || b == CHAR_U);
                feed(b, 1'b0);
                return;
            end else if (pick < 96) begin
                feed(CHAR_BACKSLASH, 1'b0);
                feed(CHAR_U, 1'b0);
                repeat ($urandom_range(3)) feed(hex_char(4'($urandom_range(15))), 1'b0);
                do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
                feed(b, 1'b0);
                return;
            end else begin
                case ($urandom_range(2))
                    0: feed(CHAR_BACKSLASH, 1'b0);
                    1: begin
                        feed(CHAR_BACKSLASH, 1'b0);
                        feed(CHAR_U, 1'b0);
                        repeat ($urandom_range(3)) feed(hex_char(4'($urandom_range(15))), 1'b0);
                    end
                    default: ;
                endcase
                feed(8'($urandom_range(255)), 1'b1);
                return;
            end
        end
        if ($urandom_range(19) == 0) feed(8'($urandom_range(255)), 1'b1);
        else feed(CHAR_QUOTE, 1'b0);
    endtask

    // Output side: random backpressure and comparison against the oldest expectation.
    initial begin
        t_result want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                results_seen++;
                if (out_ch.status == ST_DONE) strings_done++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result byte=%h status=%0d last=%b", $time,
                             out_ch.out_byte, out_ch.status, out_ch.last);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.out_byte !== want.out_byte) begin
                        mismatches++;
                        $display("%0t: out_byte expected %h, actual %h", $time,
                                 want.out_byte, out_ch.out_byte);
                    end
                    if (out_ch.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, actual %0d", $time,
                                 want.status, out_ch.status);
                    end
                    if (out_ch.last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b, actual %b", $time,
                                 want.last, out_ch.last);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        int      n;
        t_result r [3];
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        src_idle_pct = 24;
        snk_idle_pct = 76;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k]) begin
            transfer_item(script[k].in_byte, script[k].eoi);
            unescape_step(script[k].in_byte, script[k].eoi, n, r);
            if (script[k].typed) begin
                if (script[k].n_want != 2'd0) queue_result(script[k].want);
            end else begin
                for (int j = 0; j < n; j++) queue_result(r[j]);
            end
        end

        while (items_sent < 140) send_random_string();
        src_idle_pct = 76;
        snk_idle_pct = 24;
        while (items_sent < 280) send_random_string();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (items_sent < 420) send_random_string();
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Decoded %0d input bytes into %0d checked results, %0d strings closed.",
                 items_sent, results_seen, strings_done);
        $display("Field mismatches or unexpected results: %0d.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
